[hdl/u8u16_pkg.sv]
package u8u16_pkg;

  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned UnitWidth  = 16;
  localparam int unsigned PointWidth = 21;

  localparam logic [UnitWidth-1:0]  ReplUnit     = 16'hFFFD;
  localparam logic [PointWidth-1:0] SurrLowest   = 21'h00D800;
  localparam logic [PointWidth-1:0] SurrHighest  = 21'h00DFFF;
  localparam logic [PointWidth-1:0] PointHighest = 21'h10FFFF;

  // Open sequence: lead byte, continuation bytes needed and taken, gathered bits.
  typedef struct packed {
    logic [ByteWidth-1:0]  lead;
    logic [1:0]            expected;
    logic [1:0]            received;
    logic [PointWidth-1:0] partial;
  } seq_state_t;

  // Code units that one byte produces, first unit in units[0].
  typedef struct packed {
    logic [1:0]                count;
    logic [1:0][UnitWidth-1:0] units;
  } step_out_t;

endpackage

[hdl/u8u16_byte_if.sv]
interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source  (output valid, output data_byte, output last_byte, input ready);
  modport sink    (input valid, input data_byte, input last_byte, output ready);
  modport monitor (input valid, input data_byte, input last_byte, input ready);
endinterface

[hdl/u8u16_unit_if.sv]
interface u8u16_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last_of_run;
  logic        end_of_text;

  modport source  (output valid, output code_unit, output last_of_run, output end_of_text,
                   input ready);
  modport sink    (input valid, input code_unit, input last_of_run, input end_of_text,
                   output ready);
  modport monitor (input valid, input code_unit, input last_of_run, input end_of_text,
                   input ready);
endinterface

[hdl/u8u16_step.sv]
module u8u16_step (
  input  u8u16_pkg::seq_state_t state_i,
  input  logic [7:0]            data_i,
  input  logic                  last_i,
  output u8u16_pkg::seq_state_t state_o,
  output u8u16_pkg::step_out_t  res_o
);
  import u8u16_pkg::*;

  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } lead_kind_e;

  lead_kind_e            kind;
  logic                  seq_open;
  logic                  restricted;
  logic                  cont_ok;
  logic [PointWidth-1:0] acc;
  logic [1:0]            rec;
  logic [19:0]           offs;

  always_comb begin
    priority if (data_i < 8'h80) begin
      kind = LEAD_ASCII;
    end else if (data_i >= 8'hC2 && data_i <= 8'hDF) begin
      kind = LEAD_TWO;
    end else if (data_i >= 8'hE0 && data_i <= 8'hEF) begin
      kind = LEAD_THREE;
    end else if (data_i >= 8'hF0 && data_i <= 8'hF4) begin
      kind = LEAD_FOUR;
    end else begin
      kind = LEAD_BAD;
    end
  end

  assign seq_open   = (state_i.expected != 2'd0);
  // Second byte ranges that exclude overlong forms and points past U+10FFFF
  assign restricted = (state_i.received == 2'd0) &&
                      ((state_i.lead == 8'hE0 && data_i < 8'hA0) ||
                       (state_i.lead == 8'hF0 && data_i < 8'h90) ||
                       (state_i.lead == 8'hF4 && data_i > 8'h8F));
  assign cont_ok    = (data_i[7:6] == 2'b10) && !restricted;
  assign acc        = {state_i.partial[PointWidth-7:0], data_i[5:0]};
  assign rec        = state_i.received + 2'd1;
  assign offs       = acc[19:0] - 20'h10000;

  always_comb begin
    logic do_lead;
    do_lead = 1'b0;
    state_o = state_i;
    res_o   = '0;

    if (seq_open) begin
      if (cont_ok) begin
        if (rec >= state_i.expected) begin
          state_o = '0;
          if ((acc >= SurrLowest && acc <= SurrHighest) || acc > PointHighest) begin
            res_o.units[res_o.count[0]] = ReplUnit;
            res_o.count                 = res_o.count + 2'd1;
          end else if (acc[20:16] != 5'd0) begin
            res_o.units[0] = {6'b110110, offs[19:10]};
            res_o.units[1] = {6'b110111, offs[9:0]};
            res_o.count    = 2'd2;
          end else begin
            res_o.units[res_o.count[0]] = acc[15:0];
            res_o.count                 = res_o.count + 2'd1;
          end
        end else begin
          state_o.partial  = acc;
          state_o.received = rec;
        end
      end else begin
        // Close the broken sequence, then take the byte again as a lead
        state_o                     = '0;
        res_o.units[res_o.count[0]] = ReplUnit;
        res_o.count                 = res_o.count + 2'd1;
        do_lead                     = 1'b1;
      end
    end else begin
      do_lead = 1'b1;
    end

    if (do_lead) begin
      unique case (kind)
        LEAD_ASCII: begin
          res_o.units[res_o.count[0]] = {8'h00, data_i};
          res_o.count                 = res_o.count + 2'd1;
        end
        LEAD_TWO: begin
          state_o = '{lead: data_i, expected: 2'd1, received: 2'd0,
                      partial: {16'd0, data_i[4:0]}};
        end
        LEAD_THREE: begin
          state_o = '{lead: data_i, expected: 2'd2, received: 2'd0,
                      partial: {17'd0, data_i[3:0]}};
        end
        LEAD_FOUR: begin
          state_o = '{lead: data_i, expected: 2'd3, received: 2'd0,
                      partial: {18'd0, data_i[2:0]}};
        end
        default: begin
          res_o.units[res_o.count[0]] = ReplUnit;
          res_o.count                 = res_o.count + 2'd1;
        end
      endcase
    end

    // Truncated prefix at end of text
    if (last_i && state_o.expected != 2'd0) begin
      state_o                     = '0;
      res_o.units[res_o.count[0]] = ReplUnit;
      res_o.count                 = res_o.count + 2'd1;
    end
  end

endmodule

[hdl/utf8_to_utf16_decoder.sv]
// Path: a byte transferred at the input passes the input register, then the result
// register, before its first code unit shows at the output.
// Throughput: one byte per cycle while the output keeps up; a surrogate pair, or a
// replacement plus a second unit, holds the two-entry result register till both exit.
// Reset (rst_ni low, asynchronous): no sequence open, input and result stages empty.
module utf8_to_utf16_decoder (
  input logic         clk_i,
  input logic         rst_ni,
  u8u16_byte_if.sink   byte_i,
  u8u16_unit_if.source unit_o
);
  import u8u16_pkg::*;

  // Input register: one byte waiting to be decoded against the sequence state.
  logic                 in_valid_q;
  logic [ByteWidth-1:0] in_data_q;
  logic                 in_last_q;

  // Sequence state, advanced once per decoded byte.
  seq_state_t seq_q;
  seq_state_t seq_d;
  step_out_t  step;

  // Result register: up to two code units, the head in units_q[0].
  logic [1:0]                count_q;
  logic [1:0][UnitWidth-1:0] units_q;
  logic                      eot_q;

  logic out_pop;
  logic res_free;
  logic advance;

  u8u16_step u_step (
    .state_i (seq_q),
    .data_i  (in_data_q),
    .last_i  (in_last_q),
    .state_o (seq_d),
    .res_o   (step)
  );

  // The result register takes a new run when it is empty or its last unit
  // leaves in this cycle. A byte with no units never waits for it.
  assign out_pop  = (count_q != 2'd0) && unit_o.ready;
  assign res_free = (count_q == 2'd0) || (count_q == 2'd1 && unit_o.ready);
  assign advance  = in_valid_q && ((step.count == 2'd0) || res_free);

  // Take a new byte whenever the input register empties in this cycle.
  assign byte_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (byte_i.ready) begin
      in_valid_q <= byte_i.valid;
    end
  end

  // Payload of the input register: load on every transfer, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_data_q <= byte_i.data_byte;
      in_last_q <= byte_i.last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= '0;
    end else if (advance) begin
      seq_q <= seq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else if (advance && step.count != 2'd0) begin
      count_q <= step.count;
    end else if (out_pop) begin
      count_q <= count_q - 2'd1;
    end
  end

  // Load a fresh run, or shift the second unit to the head after a transfer.
  always_ff @(posedge clk_i) begin
    if (advance && step.count != 2'd0) begin
      units_q <= step.units;
      eot_q   <= in_last_q;
    end else if (out_pop) begin
      units_q[0] <= units_q[1];
    end
  end

  assign unit_o.valid       = (count_q != 2'd0);
  assign unit_o.code_unit   = units_q[0];
  assign unit_o.last_of_run = (count_q == 2'd1);
  assign unit_o.end_of_text = (count_q == 2'd1) && eot_q;

endmodule

[hdl/u8u16_checker.sv]
module u8u16_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_unit_i,
  input logic        out_last_i,
  input logic        out_eot_i
);

  logic out_xfer;
  logic high_surr;

  assign out_xfer  = out_valid_i && out_ready_i;
  assign high_surr = (out_unit_i[15:10] == 6'b110110);

  // Nothing is offered while reset is held.
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

  // A stalled code unit holds until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_unit_i) &&
      $stable(out_last_i) && $stable(out_eot_i))
    else $error("output changed while stalled");

  // A high surrogate never ends a run.
  a_high_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && high_surr |-> !out_last_i)
    else $error("high surrogate ends a run");

  // The low half of a pair follows at once.
  a_pair_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && high_surr |=> out_valid_i && out_unit_i[15:10] == 6'b110111)
    else $error("high surrogate not followed by low surrogate");

  // An empty result register never holds off the input.
  a_empty_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

endmodule

bind utf8_to_utf16_decoder u8u16_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (byte_i.valid),
  .in_ready_i  (byte_i.ready),
  .out_valid_i (unit_o.valid),
  .out_ready_i (unit_o.ready),
  .out_unit_i  (unit_o.code_unit),
  .out_last_i  (unit_o.last_of_run),
  .out_eot_i   (unit_o.end_of_text)
);

[test/utf8_to_utf16_decoder_tb.sv]
`timescale 1ns / 100ps

module utf8_to_utf16_decoder_tb;
  import u8u16_pkg::*;

  localparam int unsigned ClkHalfNs     = 6;
  localparam int unsigned ResetCycles   = 8;
  localparam int unsigned NumDirected   = 25;
  localparam int unsigned PhaseBytes    = 135;     // random bytes per idling phase
  localparam int unsigned HoldOffCycles = 200;     // long receiver stall, fills the block
  localparam int unsigned DrainCycles   = 8;       // drain time past the two-stage pipeline
  localparam int unsigned MaxReports    = 10;
  localparam longint      RunLimitNs    = 3_000_000;

  // Surrogate bases for supplementary code points.
  localparam logic [UnitWidth-1:0]  HighSurrBase = 16'hD800;
  localparam logic [UnitWidth-1:0]  LowSurrBase  = 16'hDC00;
  localparam logic [PointWidth-1:0] SuppFirst    = 21'h010000;

  localparam logic Pinned = 1'b1;   // expected unit typed into the table
  localparam logic Free   = 1'b0;   // expected units come from the decode model

  // One expected code unit as it should leave the block.
  typedef struct packed {
    logic [UnitWidth-1:0] code_unit;
    logic                 last_of_run;
    logic                 end_of_text;
  } unit_rec_t;

  // One row of the directed table.
  typedef struct packed {
    logic [ByteWidth-1:0] data;
    logic                 last;
    logic                 pinned;
    logic [UnitWidth-1:0] want_unit;
  } stim_row_t;

  // Directed bytes: ASCII extremes, bad leads, restricted second bytes,
  // a broken sequence, an encoded surrogate, both four-byte extremes and a
  // prefix cut short by the end of the text.
  localparam stim_row_t DirectedRows [NumDirected] = '{
    '{8'h00, 1'b0, Pinned, 16'h0000},   // lowest byte straight after reset
    '{8'h7F, 1'b0, Pinned, 16'h007F},   // highest ASCII
    '{8'h80, 1'b0, Pinned, ReplUnit},   // stray continuation as lead
    '{8'hFF, 1'b1, Pinned, ReplUnit},   // bad lead closing a text
    '{8'hE0, 1'b0, Free,   16'h0000},   // lowest three-byte form
    '{8'hA0, 1'b0, Free,   16'h0000},
    '{8'h80, 1'b0, Free,   16'h0000},
    '{8'hE0, 1'b0, Free,   16'h0000},   // overlong: E0 then 9F
    '{8'h9F, 1'b0, Free,   16'h0000},
    '{8'hED, 1'b0, Free,   16'h0000},   // encoded surrogate D800
    '{8'hA0, 1'b0, Free,   16'h0000},
    '{8'h80, 1'b0, Pinned, ReplUnit},
    '{8'hF0, 1'b0, Free,   16'h0000},   // U+10000, first surrogate pair
    '{8'h90, 1'b0, Free,   16'h0000},
    '{8'h80, 1'b0, Free,   16'h0000},
    '{8'h80, 1'b0, Free,   16'h0000},
    '{8'hF4, 1'b0, Free,   16'h0000},   // U+10FFFF, last surrogate pair
    '{8'h8F, 1'b0, Free,   16'h0000},
    '{8'hBF, 1'b0, Free,   16'h0000},
    '{8'hBF, 1'b0, Free,   16'h0000},
    '{8'hF0, 1'b0, Free,   16'h0000},   // overlong four-byte: F0 then 8F
    '{8'h8F, 1'b0, Free,   16'h0000},
    '{8'hF4, 1'b0, Free,   16'h0000},   // beyond U+10FFFF: F4 then 90
    '{8'h90, 1'b0, Free,   16'h0000},
    '{8'hC3, 1'b1, Pinned, ReplUnit}    // open prefix cut off by end of text
  };

  logic clk_i;
  logic rst_ni;

  u8u16_byte_if byte_if ();
  u8u16_unit_if unit_if ();

  utf8_to_utf16_decoder i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .unit_o (unit_if)
  );

  // Decode model state: the open sequence, and the code units still owed.
  seq_state_t           open_seq;
  unit_rec_t            owed_units [$];
  logic [UnitWidth-1:0] step_units [$];   // units of the byte being decoded
  logic [ByteWidth-1:0] char_bytes [$];   // bytes of one generated character

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned bytes_sent;
  int unsigned fail_cnt;
  int unsigned hold_request;
  int unsigned hold_served;
  int unsigned hold_left;

  // Clock: 12 ns period.
  initial clk_i = 1'b0;
  always #(ClkHalfNs) clk_i = ~clk_i;

  // Hard stop in case the block hangs.
  initial begin
    #(RunLimitNs);
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Decode model
  // ---------------------------------------------------------------------------

  // A byte never yields more than two units; drop anything beyond that.
  function automatic void push_unit(input logic [UnitWidth-1:0] cu);
    if (step_units.size() < 2) step_units.push_back(cu);
  endfunction

  // Emit a code point, as a surrogate pair from U+10000 upwards.
  function automatic void push_point(input logic [PointWidth-1:0] cp);
    logic [19:0] offs;
    if (cp >= SuppFirst) begin
      offs = 20'(cp - SuppFirst);
      push_unit(HighSurrBase + 16'(offs[19:10]));
      push_unit(LowSurrBase + 16'(offs[9:0]));
    end else begin
      push_unit(cp[UnitWidth-1:0]);
    end
  endfunction

  // Take a byte as the start of a character: ASCII goes straight out, a
  // valid lead opens a sequence, anything else is replaced.
  function automatic void take_lead(input logic [ByteWidth-1:0] b);
    if (b < 8'h80) begin
      push_unit(16'(b));
    end else if (b >= 8'hC2 && b <= 8'hDF) begin
      open_seq = '{lead: b, expected: 2'd1, received: 2'd0, partial: 21'(b[4:0])};
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      open_seq = '{lead: b, expected: 2'd2, received: 2'd0, partial: 21'(b[3:0])};
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      open_seq = '{lead: b, expected: 2'd3, received: 2'd0, partial: 21'(b[2:0])};
    end else begin
      push_unit(ReplUnit);
    end
  endfunction

  // Continuation check, with the narrowed second-byte ranges after E0, F0, F4.
  function automatic logic cont_ok(input logic [ByteWidth-1:0] b);
    if (b[7:6] != 2'b10) return 1'b0;
    if (open_seq.received == 2'd0) begin
      if (open_seq.lead == 8'hE0 && b < 8'hA0) return 1'b0;
      if (open_seq.lead == 8'hF0 && b < 8'h90) return 1'b0;
      if (open_seq.lead == 8'hF4 && b > 8'h8F) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Decode one byte into step_units, advancing the open sequence.
  function automatic void decode_byte(input logic [ByteWidth-1:0] b, input logic last);
    logic [PointWidth-1:0] cp;
    step_units.delete();
    if (open_seq.expected != 2'd0) begin
      if (cont_ok(b)) begin
        open_seq.partial  = {open_seq.partial[PointWidth-7:0], b[5:0]};
        open_seq.received = open_seq.received + 2'd1;
        if (open_seq.received >= open_seq.expected) begin
          cp = open_seq.partial;
          if ((cp >= SurrLowest && cp <= SurrHighest) || cp > PointHighest)
            cp = 21'(ReplUnit);
          open_seq = '0;
          push_point(cp);
        end
      end else begin
        // Close the broken sequence, then take this byte afresh.
        open_seq = '0;
        push_unit(ReplUnit);
        take_lead(b);
      end
    end else begin
      take_lead(b);
    end
    // An unfinished prefix at end of text collapses into one replacement.
    if (last && open_seq.expected != 2'd0) begin
      open_seq = '0;
      push_unit(ReplUnit);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offer one byte, hold it until transferred, then queue the units it owes.
  // A pinned row replaces the decoded units by the single unit in the table.
  task automatic send_byte(input logic [ByteWidth-1:0] b, input logic last,
                           input logic pinned, input logic [UnitWidth-1:0] want_unit);
    unit_rec_t rec;
    int        n;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= b;
    byte_if.last_byte <= last;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);

    decode_byte(b, last);
    if (pinned) begin
      step_units.delete();
      step_units.push_back(want_unit);
    end
    n = step_units.size();
    for (int i = 0; i < n; i++) begin
      rec.code_unit   = step_units[i];
      rec.last_of_run = (i == n - 1);
      rec.end_of_text = last && (i == n - 1);
      owed_units.push_back(rec);
    end
    bytes_sent++;
  endtask

  // Build one character: mostly well-formed with random content, some noise
  // bytes, and now and then a sequence cut short or with a byte overwritten.
  task automatic gen_char();
    int unsigned           kind;
    logic [PointWidth-1:0] cp;
    int unsigned           keep;
    char_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      char_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (kind < 35)      cp = 21'($urandom_range('h0, 'h7F));
    else if (kind < 55) cp = 21'($urandom_range('h80, 'h7FF));
    else if (kind < 62) cp = 21'($urandom_range('hD800, 'hDFFF));
    else if (kind < 78) cp = 21'($urandom_range('h800, 'hFFFF));
    else                cp = 21'($urandom_range('h10000, 'h10FFFF));

    if (cp < 21'h80) begin
      char_bytes.push_back(cp[7:0]);
    end else if (cp < 21'h800) begin
      char_bytes.push_back({3'b110, cp[10:6]});
      char_bytes.push_back({2'b10, cp[5:0]});
    end else if (cp < SuppFirst) begin
      char_bytes.push_back({4'b1110, cp[15:12]});
      char_bytes.push_back({2'b10, cp[11:6]});
      char_bytes.push_back({2'b10, cp[5:0]});
    end else begin
      char_bytes.push_back({5'b11110, cp[20:18]});
      char_bytes.push_back({2'b10, cp[17:12]});
      char_bytes.push_back({2'b10, cp[11:6]});
      char_bytes.push_back({2'b10, cp[5:0]});
    end

    if (char_bytes.size() > 1 && $urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1) == 0) begin
        keep = $urandom_range(1, char_bytes.size() - 1);
        while (char_bytes.size() > keep) char_bytes.delete(char_bytes.size() - 1);
      end else begin
        char_bytes[$urandom_range(1, char_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      end
    end
  endtask

  // Stimulus: reset, directed table, then three random phases with
  // different idling; drain between phases so the sender pauses on an
  // empty pipeline.
  initial begin
    rst_ni            = 1'b0;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = '0;
    byte_if.last_byte = 1'b0;
    open_seq          = '0;
    bytes_sent        = 0;
    fail_cnt          = 0;
    hold_request      = 0;
    send_idle_pct     = 27;
    recv_idle_pct     = 69;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedRows[i])
      send_byte(DirectedRows[i].data, DirectedRows[i].last,
                DirectedRows[i].pinned, DirectedRows[i].want_unit);

    for (int phase = 0; phase < 3; phase++) begin
      int unsigned start;
      case (phase)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 69;
        end
        1: begin
          send_idle_pct = 69;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // Stall the receiver for a long stretch while bytes keep coming.
          hold_request++;
        end
      endcase
      start = bytes_sent;
      while (bytes_sent - start < PhaseBytes) begin
        gen_char();
        foreach (char_bytes[k])
          send_byte(char_bytes[k], $urandom_range(0, 19) == 0, Free, '0);
      end
      // Pause the sender until every owed unit has come out.
      byte_if.valid <= 1'b0;
      while (owed_units.size() != 0) @(posedge clk_i);
      @(posedge clk_i);
    end

    // Let the pipeline settle and catch any stray unit.
    repeat (DrainCycles) @(posedge clk_i);
    if (owed_units.size() != 0) begin
      $display("%0d code units never arrived", owed_units.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, plus a counted long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin
    unit_if.ready = 1'b0;
    hold_served   = 0;
    hold_left     = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request != hold_served) begin
        hold_served = hold_request;
        hold_left   = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        unit_if.ready <= 1'b0;
      end else begin
        unit_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare every transferred unit with the oldest owed one.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_units
    unit_rec_t want;
    unit_rec_t got;
    if (rst_ni && unit_if.valid && unit_if.ready) begin
      got = '{code_unit: unit_if.code_unit, last_of_run: unit_if.last_of_run,
              end_of_text: unit_if.end_of_text};
      if (owed_units.size() == 0) begin
        if (fail_cnt < MaxReports)
          $display("unexpected unit %h last_of_run %b end_of_text %b",
                   got.code_unit, got.last_of_run, got.end_of_text);
        fail_cnt++;
      end else begin
        want = owed_units.pop_front();
        if (got.code_unit != want.code_unit || got.last_of_run != want.last_of_run ||
            got.end_of_text != want.end_of_text) begin
          if (fail_cnt < MaxReports)
            $display("mismatch: want %h/%b/%b got %h/%b/%b (unit/last_of_run/end_of_text)",
                     want.code_unit, want.last_of_run, want.end_of_text,
                     got.code_unit, got.last_of_run, got.end_of_text);
          fail_cnt++;
        end
      end
    end
  end

endmodule

[filelist.f]
hdl/u8u16_pkg.sv
hdl/u8u16_byte_if.sv
hdl/u8u16_unit_if.sv
hdl/u8u16_step.sv
hdl/utf8_to_utf16_decoder.sv
hdl/u8u16_checker.sv
test/utf8_to_utf16_decoder_tb.sv
